// ===== design/klcrs_pkg.sv =====
// klcrs_pkg: types, codes and constants of the keyframe loop-closure radius search core
// standalone package, no dependencies; used by keyframe_loop_closure_radius_search_core

package klcrs_pkg;

   // fixed field widths
   localparam int COORD_BITS = 24;
   localparam int SESS_W     = 8;
   localparam int IDX_W      = 10;
   localparam int CFG_W      = 52;
   localparam int SEP_W      = 11;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 2;

   // squared difference and three-term sum widths
   localparam int SQ_W  = 2 * (COORD_BITS + 1);
   localparam int SUM_W = SQ_W + 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_SQ   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUPPRESS_SQ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SEP     = 2'd2;

   // register reset values
   localparam logic [CFG_W-1:0] RADIUS_SQ_RST   = 52'd25000000;
   localparam logic [CFG_W-1:0] SUPPRESS_SQ_RST = 52'd1000000;
   localparam logic [SEP_W-1:0] MIN_SEP_RST     = 11'd50;

   // actions
   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_PROCESS = 1'b1;

   // completion status codes
   localparam logic [STAT_W-1:0] STAT_SCANNED    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SUPPRESSED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTHING    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_WRITE_DONE = 2'd3;

   typedef struct packed {
      logic                         action;
      logic [IDX_W-1:0]             index;
      logic signed [COORD_BITS-1:0] pos_x_in;
      logic signed [COORD_BITS-1:0] pos_y_in;
      logic signed [COORD_BITS-1:0] pos_z_in;
      logic [SESS_W-1:0]            session_in;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  earlier_index;
      logic [IDX_W-1:0]  current_index;
      logic              is_candidate;
      logic              last_item;
      logic [STAT_W-1:0] status;
      logic              overflow;
   } rsp_type;

   // one keyframe slot of the pose memory
   typedef struct packed {
      logic [SESS_W-1:0]            session;
      logic signed [COORD_BITS-1:0] z;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] x;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_RD_LC,
      ST_LC_CHK,
      ST_SCAN
   } state_type;

   // exact squared difference of two coordinates
   function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_BITS-1:0] a,
                                               input logic signed [COORD_BITS-1:0] b);
      logic signed [COORD_BITS:0] d;
      logic signed [SQ_W-1:0]     p;
      d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
      p = d * d;
      return p;
   endfunction

endpackage

// ===== design/keyframe_loop_closure_radius_search_core.sv =====
// keyframe_loop_closure_radius_search_core: top level of the loop-closure radius search
// depends on klcrs_pkg (types, codes, squared-difference function)

// Keyframe poses (x, y, z in mm, session id) live in one synchronous memory with
// a registered read. A write transaction (action 0) stores one slot and is answered
// by a single write-done result in the following cycle; busy stays low, so another
// transaction can start in the very next cycle. A process transaction (action 1)
// advances the current keyframe and holds busy high while the memory is swept:
// the current pose is fetched, the suppression test runs against the last
// current keyframe that matched (when there is one), then one memory read per
// stored keyframe passes through a three-stage read/square/compare pipeline,
// which drains before a completion cycle. A match moves the suppression
// reference, so the entries behind it are read again. The final result comes
// out in the cycle busy drops. When nothing is pending the answer comes in the
// following cycle. Results appear for exactly one cycle with rsp_valid high and
// cannot be stalled; candidates come first, then the completion result carrying
// last_item. Configuration writes are single-cycle and are meant for idle
// periods only. Slots never written hold arbitrary data.

module keyframe_loop_closure_radius_search_core #(
   parameter int MAX_KEYFRAMES  = 1024,
   parameter int MAX_CANDIDATES = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  klcrs_pkg::req_type               req_data,
   // result channel
   output logic                             rsp_valid,
   output klcrs_pkg::rsp_type               rsp_data,
   // configuration
   input  logic                             csr_we,
   input  logic [klcrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [klcrs_pkg::CFG_W-1:0]      csr_wdata
);

   // address, count, compare and candidate counter widths
   localparam int AW  = (MAX_KEYFRAMES > 2) ? $clog2(MAX_KEYFRAMES) : 1;
   localparam int CW  = $clog2(MAX_KEYFRAMES + 1);
   localparam int XW  = (CW > klcrs_pkg::SEP_W) ? CW + 1 : klcrs_pkg::SEP_W + 1;
   localparam int CNW = $clog2(MAX_CANDIDATES + 1);

   // ---------------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------------
   klcrs_pkg::state_type               state_ff, state_in;

   // configuration registers
   logic [klcrs_pkg::CFG_W-1:0]        radius_sq_ff;
   logic [klcrs_pkg::CFG_W-1:0]        suppress_sq_ff;
   logic [klcrs_pkg::SEP_W-1:0]        min_sep_ff;

   // keyframe bookkeeping
   logic [CW-1:0]                      count_ff, count_in;
   logic [AW-1:0]                      pi_ff, pi_in;
   logic                               lc_valid_ff, lc_valid_in;
   logic [AW-1:0]                      lc_index_ff, lc_index_in;

   // current keyframe of the running transaction
   logic [AW-1:0]                      cur_ff, cur_in;
   klcrs_pkg::entry_type               cur_ent_ff;
   logic                               load_cur;

   // pose memory
   klcrs_pkg::entry_type               mem [MAX_KEYFRAMES];
   klcrs_pkg::entry_type               rd_data_ff;
   klcrs_pkg::entry_type               wr_ent;
   logic [AW-1:0]                      rd_addr;
   logic [AW-1:0]                      wr_addr;
   logic                               mem_we;

   // scan pipeline: issue counter, read stage, square stage
   logic [CW-1:0]                      scan_j_ff, scan_j_in;
   logic                               v1_ff, v1_in;
   logic [AW-1:0]                      e1_j_ff, e1_j_in;
   logic                               v2_ff, v2_in;
   logic [AW-1:0]                      p2_j_ff;
   klcrs_pkg::entry_type               p2_ent_ff;
   logic [klcrs_pkg::SQ_W-1:0]         p2_sqc_ff [3];
   logic [klcrs_pkg::SQ_W-1:0]         p2_sql_ff [3];
   logic                               p2_eq_cur_ff;
   logic                               p2_eq_lp_ff;
   logic                               p2_sep_skip_ff;

   // previous match of this transaction (suppression reference)
   logic                               lp_valid_ff, lp_valid_in;
   klcrs_pkg::entry_type               lp_ent_ff;
   logic                               lp_load;

   // candidate cap bookkeeping
   logic [CNW-1:0]                     cand_cnt_ff, cand_cnt_in;
   logic                               ovf_ff, ovf_in;

   // result register
   logic                               rsp_valid_ff, rsp_valid_in;
   klcrs_pkg::rsp_type                 rsp_ff, rsp_in;

   // ---------------------------------------------------------------------------
   // square stage: differences against the current pose and the previous match
   // ---------------------------------------------------------------------------
   logic [klcrs_pkg::SQ_W-1:0]         sqc [3];
   logic [klcrs_pkg::SQ_W-1:0]         sql [3];
   logic                               eq_cur;
   logic                               eq_lp;
   logic                               sep_skip;
   logic [XW-1:0]                      jx;
   logic [XW-1:0]                      cx;

   always_comb begin
      sqc[0]   = klcrs_pkg::sq_diff(rd_data_ff.x, cur_ent_ff.x);
      sqc[1]   = klcrs_pkg::sq_diff(rd_data_ff.y, cur_ent_ff.y);
      sqc[2]   = klcrs_pkg::sq_diff(rd_data_ff.z, cur_ent_ff.z);
      sql[0]   = klcrs_pkg::sq_diff(rd_data_ff.x, lp_ent_ff.x);
      sql[1]   = klcrs_pkg::sq_diff(rd_data_ff.y, lp_ent_ff.y);
      sql[2]   = klcrs_pkg::sq_diff(rd_data_ff.z, lp_ent_ff.z);
      eq_cur   = (rd_data_ff.session == cur_ent_ff.session);
      eq_lp    = (rd_data_ff.session == lp_ent_ff.session);
      // same session: later slots and slots closer than the minimum gap are skipped
      jx       = XW'(e1_j_ff);
      cx       = XW'(cur_ff);
      sep_skip = eq_cur && ((jx > cx) || ((cx - jx) < XW'(min_sep_ff)));
   end

   // ---------------------------------------------------------------------------
   // compare stage
   // ---------------------------------------------------------------------------
   logic [klcrs_pkg::SUM_W-1:0]        sum_c;
   logic [klcrs_pkg::SUM_W-1:0]        sum_l;
   logic                               rad_hit;
   logic                               lp_supp;
   logic                               match;
   logic                               lc_supp;

   always_comb begin
      sum_c   = klcrs_pkg::SUM_W'(p2_sqc_ff[0]) + klcrs_pkg::SUM_W'(p2_sqc_ff[1])
              + klcrs_pkg::SUM_W'(p2_sqc_ff[2]);
      sum_l   = klcrs_pkg::SUM_W'(p2_sql_ff[0]) + klcrs_pkg::SUM_W'(p2_sql_ff[1])
              + klcrs_pkg::SUM_W'(p2_sql_ff[2]);
      rad_hit = (sum_c < radius_sq_ff);
      // entry near the previous match of its session is suppressed
      lp_supp = lp_valid_ff && p2_eq_lp_ff && (sum_l < suppress_sq_ff);
      match   = v2_ff && !p2_sep_skip_ff && !lp_supp && rad_hit;
      // current keyframe near the last current keyframe that matched
      lc_supp = p2_eq_cur_ff && (sum_c < suppress_sq_ff);
   end

   // ---------------------------------------------------------------------------
   // sequencer: next state and outputs
   // ---------------------------------------------------------------------------
   logic                               idx_ok;
   logic [XW-1:0]                      wr_next_cnt;
   logic [AW-1:0]                      cur_next;
   logic                               nothing_pending;

   always_comb begin
      idx_ok          = (XW'(req_data.index) < XW'(MAX_KEYFRAMES));
      wr_next_cnt     = XW'(req_data.index) + XW'(1);
      cur_next        = pi_ff + AW'(1);
      nothing_pending = ((XW'(pi_ff) + XW'(1)) >= XW'(count_ff));

      state_in     = state_ff;
      count_in     = count_ff;
      pi_in        = pi_ff;
      lc_valid_in  = lc_valid_ff;
      lc_index_in  = lc_index_ff;
      cur_in       = cur_ff;
      load_cur     = 1'b0;
      scan_j_in    = scan_j_ff;
      v1_in        = 1'b0;
      e1_j_in      = AW'(scan_j_ff);
      v2_in        = 1'b0;
      lp_valid_in  = lp_valid_ff;
      lp_load      = 1'b0;
      cand_cnt_in  = cand_cnt_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rd_addr      = AW'(scan_j_ff);
      mem_we       = 1'b0;
      wr_addr      = AW'(req_data.index);
      wr_ent.session = req_data.session_in;
      wr_ent.z       = req_data.pos_z_in;
      wr_ent.y       = req_data.pos_y_in;
      wr_ent.x       = req_data.pos_x_in;

      case (state_ff)
         klcrs_pkg::ST_IDLE: begin
            // fetch the next current pose speculatively
            rd_addr = cur_next;
            if (start) begin
               if (req_data.action == klcrs_pkg::ACT_WRITE) begin
                  // out-of-range slots change nothing but are still answered
                  mem_we = idx_ok;
                  if (idx_ok && (wr_next_cnt > XW'(count_ff))) begin
                     count_in = CW'(wr_next_cnt);
                  end
                  rsp_valid_in     = 1'b1;
                  rsp_in.last_item = 1'b1;
                  rsp_in.status    = klcrs_pkg::STAT_WRITE_DONE;
               end else if (nothing_pending) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.last_item = 1'b1;
                  rsp_in.status    = klcrs_pkg::STAT_NOTHING;
               end else begin
                  pi_in       = cur_next;
                  cur_in      = cur_next;
                  lp_valid_in = 1'b0;
                  cand_cnt_in = '0;
                  ovf_in      = 1'b0;
                  scan_j_in   = '0;
                  state_in    = klcrs_pkg::ST_RD_CUR;
               end
            end
         end

         klcrs_pkg::ST_RD_CUR: begin
            load_cur = 1'b1;
            rd_addr  = lc_index_ff;
            state_in = lc_valid_ff ? klcrs_pkg::ST_RD_LC : klcrs_pkg::ST_SCAN;
         end

         klcrs_pkg::ST_RD_LC: begin
            // squares of the last current pose against the current one
            state_in = klcrs_pkg::ST_LC_CHK;
         end

         klcrs_pkg::ST_LC_CHK: begin
            if (lc_supp) begin
               rsp_valid_in         = 1'b1;
               rsp_in.current_index = klcrs_pkg::IDX_W'(cur_ff);
               rsp_in.last_item     = 1'b1;
               rsp_in.status        = klcrs_pkg::STAT_SUPPRESSED;
               state_in             = klcrs_pkg::ST_IDLE;
            end else begin
               state_in = klcrs_pkg::ST_SCAN;
            end
         end

         klcrs_pkg::ST_SCAN: begin
            if (match) begin
               lc_valid_in = 1'b1;
               lc_index_in = cur_ff;
               lp_valid_in = 1'b1;
               lp_load     = 1'b1;
               // entries behind the match saw the old reference: read them again
               scan_j_in   = CW'(p2_j_ff) + CW'(1);
               if (cand_cnt_ff < CNW'(MAX_CANDIDATES)) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.earlier_index = klcrs_pkg::IDX_W'(p2_j_ff);
                  rsp_in.current_index = klcrs_pkg::IDX_W'(cur_ff);
                  rsp_in.is_candidate  = 1'b1;
                  rsp_in.status        = klcrs_pkg::STAT_SCANNED;
                  cand_cnt_in          = cand_cnt_ff + CNW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               v2_in = v1_ff;
               if (scan_j_ff < count_ff) begin
                  v1_in     = 1'b1;
                  e1_j_in   = AW'(scan_j_ff);
                  scan_j_in = scan_j_ff + CW'(1);
               end else if (!v1_ff && !v2_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.current_index = klcrs_pkg::IDX_W'(cur_ff);
                  rsp_in.last_item     = 1'b1;
                  rsp_in.status        = klcrs_pkg::STAT_SCANNED;
                  rsp_in.overflow      = ovf_ff;
                  state_in             = klcrs_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = klcrs_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= klcrs_pkg::ST_IDLE;
         count_ff     <= '0;
         pi_ff        <= '0;
         lc_valid_ff  <= 1'b0;
         lc_index_ff  <= '0;
         cur_ff       <= '0;
         scan_j_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         lp_valid_ff  <= 1'b0;
         cand_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pi_ff        <= pi_in;
         lc_valid_ff  <= lc_valid_in;
         lc_index_ff  <= lc_index_in;
         cur_ff       <= cur_in;
         scan_j_ff    <= scan_j_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         lp_valid_ff  <= lp_valid_in;
         cand_cnt_ff  <= cand_cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff   <= klcrs_pkg::RADIUS_SQ_RST;
         suppress_sq_ff <= klcrs_pkg::SUPPRESS_SQ_RST;
         min_sep_ff     <= klcrs_pkg::MIN_SEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            klcrs_pkg::REG_RADIUS_SQ:   radius_sq_ff   <= csr_wdata;
            klcrs_pkg::REG_SUPPRESS_SQ: suppress_sq_ff <= csr_wdata;
            klcrs_pkg::REG_MIN_SEP:     min_sep_ff     <= klcrs_pkg::SEP_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // pose memory: one write port, one registered read port
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_ent;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // ---------------------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_cur) begin
         cur_ent_ff <= rd_data_ff;
      end
      if (lp_load) begin
         lp_ent_ff <= p2_ent_ff;
      end
      e1_j_ff        <= e1_j_in;
      p2_j_ff        <= e1_j_ff;
      p2_ent_ff      <= rd_data_ff;
      p2_sqc_ff      <= sqc;
      p2_sql_ff      <= sql;
      p2_eq_cur_ff   <= eq_cur;
      p2_eq_lp_ff    <= eq_lp;
      p2_sep_skip_ff <= sep_skip;
      rsp_ff         <= rsp_in;
   end

   assign busy      = (state_ff != klcrs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // busy only drops together with the final result of a transaction
   a_busy_ends_with_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_data.last_item))
      else $error("busy dropped without a final result");

   // the candidate counter never passes the cap
   a_cand_cap: assert property (@(posedge clock) disable iff (reset)
      cand_cnt_ff <= CNW'(MAX_CANDIDATES))
      else $error("candidate counter beyond cap");

   // no candidate can leave in the cycle right after a transaction starts
   a_no_early_cand: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !(rsp_valid && rsp_data.is_candidate))
      else $error("candidate too early after start");

   // the read stage only carries slots below the keyframe count
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (CW'(e1_j_ff) < count_ff))
      else $error("scan read beyond keyframe count");
`endif

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for keyframe_loop_closure_radius_search_core
// depends on klcrs_pkg and the core RTL; keeps its own keyframe table and search model

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KF_SLOTS    = 1024;
   localparam int MAX_CAND    = 63;
   // largest table grown before the high-slot tail, keeps sweeps short
   localparam int TABLE_ROOM  = 240;
   // a sweep of TABLE_ROOM entries with re-reads stays well under this
   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 64;
   localparam int PRINT_CAP   = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            start     = 1'b0;
   logic                            busy;
   klcrs_pkg::req_type              req_data  = '0;
   logic                            rsp_valid;
   klcrs_pkg::rsp_type              rsp_data;
   logic                            csr_we    = 1'b0;
   logic [klcrs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [klcrs_pkg::CFG_W-1:0]     csr_wdata = '0;

   keyframe_loop_closure_radius_search_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // search model: keyframe table, sweep position and register copies
   // ---------------------------------------------------------------------------
   logic signed [klcrs_pkg::COORD_BITS-1:0] kf_x    [KF_SLOTS];
   logic signed [klcrs_pkg::COORD_BITS-1:0] kf_y    [KF_SLOTS];
   logic signed [klcrs_pkg::COORD_BITS-1:0] kf_z    [KF_SLOTS];
   logic [klcrs_pkg::SESS_W-1:0]            kf_sess [KF_SLOTS];
   int                           kf_count   = 0;
   int                           sweep_pos  = 0;
   bit                           anchor_ok  = 1'b0;   // a current keyframe has matched
   int                           anchor_idx = 0;      // the last one that did

   longint unsigned radius_cfg   = 64'(klcrs_pkg::RADIUS_SQ_RST);
   longint unsigned suppress_cfg = 64'(klcrs_pkg::SUPPRESS_SQ_RST);
   int              min_sep_cfg  = int'(klcrs_pkg::MIN_SEP_RST);

   klcrs_pkg::rsp_type expected_rsps [$];   // results still owed by the core, oldest first
   klcrs_pkg::req_type pending_cmds  [$];   // transactions waiting for the driver

   int send_idle_pct = 0;
   int plan_count    = 0;        // table size as of the last queued transaction
   int error_count   = 0;
   int writes_done   = 0;
   int scans_done    = 0;
   int results_seen  = 0;
   int cands_seen    = 0;
   int drops_seen    = 0;
   int skips_seen    = 0;
   int empties_seen  = 0;
   int quiet_cycles  = 0;

   // exact squared distance between two table slots; coordinates fit 24 bits,
   // so the three-term sum never comes near 64 bits
   function automatic longint unsigned sq_dist(input int a, input int b);
      longint dx, dy, dz;
      dx = longint'(kf_x[a]) - longint'(kf_x[b]);
      dy = longint'(kf_y[a]) - longint'(kf_y[b]);
      dz = longint'(kf_z[a]) - longint'(kf_z[b]);
      return dx * dx + dy * dy + dz * dz;
   endfunction

   function automatic void push_outcome(input int earlier, input int cur, input logic cand,
                                        input logic last,
                                        input logic [klcrs_pkg::STAT_W-1:0] stat,
                                        input logic ovf);
      klcrs_pkg::rsp_type r;
      r.earlier_index = earlier[klcrs_pkg::IDX_W-1:0];
      r.current_index = cur[klcrs_pkg::IDX_W-1:0];
      r.is_candidate  = cand;
      r.last_item     = last;
      r.status        = stat;
      r.overflow      = ovf;
      expected_rsps.push_back(r);
   endfunction

   // works out every result one accepted transaction causes
   function automatic void predict_search(input klcrs_pkg::req_type cmd);
      int          cur, j, prev_hit, n_hits;
      bit          prev_ok, dropped;
      logic [klcrs_pkg::SESS_W-1:0] cur_sess;
      if (cmd.action == klcrs_pkg::ACT_WRITE) begin
         kf_x[cmd.index]    = cmd.pos_x_in;
         kf_y[cmd.index]    = cmd.pos_y_in;
         kf_z[cmd.index]    = cmd.pos_z_in;
         kf_sess[cmd.index] = cmd.session_in;
         if (int'(cmd.index) + 1 > kf_count) kf_count = int'(cmd.index) + 1;
         push_outcome(0, 0, 1'b0, 1'b1, klcrs_pkg::STAT_WRITE_DONE, 1'b0);
         return;
      end
      // no keyframe left behind the sweep position
      if (sweep_pos + 1 >= kf_count) begin
         push_outcome(0, 0, 1'b0, 1'b1, klcrs_pkg::STAT_NOTHING, 1'b0);
         return;
      end
      sweep_pos++;
      cur      = sweep_pos;
      cur_sess = kf_sess[cur];
      // whole keyframe skipped when it sits close to the last matching one
      if (anchor_ok && kf_sess[anchor_idx] == cur_sess &&
          sq_dist(cur, anchor_idx) < suppress_cfg) begin
         push_outcome(0, cur, 1'b0, 1'b1, klcrs_pkg::STAT_SUPPRESSED, 1'b0);
         return;
      end
      n_hits   = 0;
      prev_ok  = 1'b0;
      prev_hit = 0;
      dropped  = 1'b0;
      for (j = 0; j < kf_count; j++) begin
         // same session too close in index, later slots give a negative gap
         if (kf_sess[j] == cur_sess && cur - j < min_sep_cfg) continue;
         // near the previous match of that session
         if (prev_ok && kf_sess[prev_hit] == kf_sess[j] &&
             sq_dist(j, prev_hit) < suppress_cfg) continue;
         if (sq_dist(j, cur) < radius_cfg) begin
            anchor_ok  = 1'b1;
            anchor_idx = cur;
            prev_ok    = 1'b1;
            prev_hit   = j;
            if (n_hits < MAX_CAND) begin
               push_outcome(j, cur, 1'b1, 1'b0, klcrs_pkg::STAT_SCANNED, 1'b0);
               n_hits++;
            end else begin
               dropped = 1'b1;   // past the cap, still moves the suppression point
            end
         end
      end
      push_outcome(0, cur, 1'b0, 1'b1, klcrs_pkg::STAT_SCANNED, dropped);
   endfunction

   task automatic report_fault(input string what);
      if (error_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) report_fault($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // ---------------------------------------------------------------------------
   // driver: one transaction at a time from pending_cmds, random idle cycles
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_search(req_data);
            if (req_data.action == klcrs_pkg::ACT_WRITE) writes_done++;
            else scans_done++;
         end
         // slot free: nothing offered, or the offer was just taken
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               start    <= 1'b1;
               req_data <= pending_cmds.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: every strobed result against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      klcrs_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_data.is_candidate) cands_seen++;
         if (rsp_data.last_item && rsp_data.overflow) drops_seen++;
         if (rsp_data.last_item && rsp_data.status == klcrs_pkg::STAT_SUPPRESSED)
            skips_seen++;
         if (rsp_data.last_item && rsp_data.status == klcrs_pkg::STAT_NOTHING)
            empties_seen++;
         if (expected_rsps.size() == 0) begin
            report_fault("result transaction with nothing expected");
         end else begin
            want = expected_rsps.pop_front();
            check_field("earlier_index", int'(rsp_data.earlier_index),
                        int'(want.earlier_index));
            check_field("current_index", int'(rsp_data.current_index),
                        int'(want.current_index));
            check_field("is_candidate", int'(rsp_data.is_candidate), int'(want.is_candidate));
            check_field("last_item", int'(rsp_data.last_item), int'(want.last_item));
            check_field("status", int'(rsp_data.status), int'(want.status));
            check_field("overflow", int'(rsp_data.overflow), int'(want.overflow));
         end
      end
   end

   // watchdog: cycles with neither a command nor a result taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_write(input int idx, input int x, input int y,
                                       input int z, input int sess);
      klcrs_pkg::req_type cmd;
      cmd.action     = klcrs_pkg::ACT_WRITE;
      cmd.index      = idx[klcrs_pkg::IDX_W-1:0];
      cmd.pos_x_in   = x[klcrs_pkg::COORD_BITS-1:0];
      cmd.pos_y_in   = y[klcrs_pkg::COORD_BITS-1:0];
      cmd.pos_z_in   = z[klcrs_pkg::COORD_BITS-1:0];
      cmd.session_in = sess[klcrs_pkg::SESS_W-1:0];
      pending_cmds.push_back(cmd);
      if (idx + 1 > plan_count) plan_count = idx + 1;
   endfunction

   // the core ignores everything but the action here, so the rest is noise
   function automatic void queue_process();
      klcrs_pkg::req_type cmd;
      cmd.action     = klcrs_pkg::ACT_PROCESS;
      cmd.index      = klcrs_pkg::IDX_W'($urandom());
      cmd.pos_x_in   = klcrs_pkg::COORD_BITS'($urandom());
      cmd.pos_y_in   = klcrs_pkg::COORD_BITS'($urandom());
      cmd.pos_z_in   = klcrs_pkg::COORD_BITS'($urandom());
      cmd.session_in = klcrs_pkg::SESS_W'($urandom());
      pending_cmds.push_back(cmd);
   endfunction

   function automatic int pick_coord(input int ctr, input int spread);
      int v;
      v = ctr + int'($urandom_range(2 * spread)) - spread;
      return v;
   endfunction

   // block until the core is quiet: nothing queued, offered, owed or in flight
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0 || busy);
   endtask

   task automatic csr_write(input logic [klcrs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [klcrs_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         klcrs_pkg::REG_RADIUS_SQ:   radius_cfg   = 64'(value);
         klcrs_pkg::REG_SUPPRESS_SQ: suppress_cfg = 64'(value);
         klcrs_pkg::REG_MIN_SEP:     min_sep_cfg  = int'(value[klcrs_pkg::SEP_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [klcrs_pkg::CFG_W-1:0] radius,
                                 input logic [klcrs_pkg::CFG_W-1:0] supp,
                                 input int sep);
      wait_idle();
      csr_write(klcrs_pkg::REG_RADIUS_SQ, radius);
      csr_write(klcrs_pkg::REG_SUPPRESS_SQ, supp);
      csr_write(klcrs_pkg::REG_MIN_SEP, klcrs_pkg::CFG_W'(sep));
   endtask

   // mostly appended keyframes clustered around one spot and sweeps over them,
   // with some overwrites and far-flung noise keyframes mixed in
   task automatic random_phase(input int n_items);
      int k, roll, spread, cx, cy, cz;
      cx = int'($urandom_range(16_000_000)) - 8_000_000;
      cy = int'($urandom_range(16_000_000)) - 8_000_000;
      cz = int'($urandom_range(16_000_000)) - 8_000_000;
      for (k = 0; k < n_items; k++) begin
         roll = $urandom_range(99);
         case ($urandom_range(2))
            0:       spread = 400;
            1:       spread = 2500;
            default: spread = 6000;
         endcase
         if (roll < 50 && plan_count < TABLE_ROOM) begin
            queue_write(plan_count, pick_coord(cx, spread), pick_coord(cy, spread),
                        pick_coord(cz, spread), $urandom_range(3));
         end else if (roll < 58 && plan_count > 0) begin
            queue_write($urandom_range(plan_count - 1), pick_coord(cx, spread),
                        pick_coord(cy, spread), pick_coord(cz, spread), $urandom_range(3));
         end else if (roll < 62 && plan_count < TABLE_ROOM) begin
            queue_write(plan_count, $urandom(), $urandom(), $urandom(), $urandom());
         end else begin
            queue_process();
         end
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset settings, one transaction at a time so the
      // sender waits out every result before the next command
      queue_process();                       // empty table
      wait_idle();
      queue_write(0, 0, 0, 0, 0);
      wait_idle();
      queue_write(1, 1000, 0, 0, 1);
      wait_idle();
      queue_process();                       // slot 1 pairs with slot 0
      wait_idle();
      queue_write(2, 8388607, -8388608, 8388607, 255);
      wait_idle();
      queue_write(3, -8388608, 8388607, -8388608, 255);
      wait_idle();
      queue_write(4, 100, 100, 100, 1);      // close to slot 1, same session
      wait_idle();
      queue_write(5, 3000, 0, 0, 1);
      wait_idle();
      queue_write(1, 900, 0, 0, 1);          // overwrite
      wait_idle();
      queue_write(6, 3100, 0, 0, 2);
      wait_idle();
      queue_write(7, 2900, 50, 0, 2);        // repeat of slot 6, gets suppressed
      wait_idle();
      for (k = 0; k < 7; k++) begin          // sweeps 2..7, then nothing left
         queue_process();
         wait_idle();
      end

      // moderate radius, tight separation, no idling
      send_idle_pct = 0;
      apply_settings(52'd9_000_000, 52'd250_000, 3);
      random_phase(80);

      // every slot the separation rule lets through matches and nothing suppresses: the cap overflows
      send_idle_pct = 75;
      apply_settings({klcrs_pkg::CFG_W{1'b1}}, '0, 0);
      random_phase(80);

      // nothing matches, every same-session current keyframe is skipped
      send_idle_pct = 10;
      apply_settings('0, {klcrs_pkg::CFG_W{1'b1}}, 1024);
      random_phase(60);

      // random settings: radius and suppression around the reset values, smaller separation
      send_idle_pct = 0;
      apply_settings(klcrs_pkg::CFG_W'($urandom_range(50_000_000)),
                     klcrs_pkg::CFG_W'($urandom_range(4_000_000)),
                     $urandom_range(20));
      random_phase(120);

      // high slots last: no sweep follows, so the gaps below them are never read
      send_idle_pct = 75;
      queue_write(1023, -8388608, 8388607, -8388608, 0);
      queue_write(512, $urandom(), $urandom(), $urandom(), $urandom());
      queue_write(341, $urandom(), $urandom(), $urandom(), $urandom());
      queue_write(682, $urandom(), $urandom(), $urandom(), $urandom());
      for (k = 0; k < 4; k++)
         queue_write($urandom_range(KF_SLOTS - 1), $urandom(), $urandom(), $urandom(),
                     $urandom());
      wait_idle();

      // let any stray result surface before judging
      repeat (DRAIN_WAIT) @(posedge clock);
      while (expected_rsps.size() != 0) begin
         void'(expected_rsps.pop_front());
         report_fault("expected result never arrived");
      end

      $display("run covered %0d keyframe writes and %0d sweeps, %0d results checked",
               writes_done, scans_done, results_seen);
      $display("  %0d candidates, %0d capped sweeps, %0d skipped keyframes, %0d empty, %0d errors",
               cands_seen, drops_seen, skips_seen, empties_seen, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/klcrs_pkg.sv
design/keyframe_loop_closure_radius_search_core.sv
bench/tb.sv
